>>> hdl/pfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pfd_pkg;

  localparam int LW = 5;
  localparam int SIDE = 5;
  localparam int CELLS = 25;
  localparam int ALPHA = 26;

  typedef logic [LW-1:0] letter_t;
  typedef logic [2:0] coord_t;

  localparam letter_t LETTER_I = 5'd8;
  localparam letter_t LETTER_J = 5'd9;
  localparam letter_t LETTER_Z = 5'd25;

  localparam logic [1:0] CMD_CLEAR   = 2'd0;
  localparam logic [1:0] CMD_ADD     = 2'd1;
  localparam logic [1:0] CMD_FINISH  = 2'd2;
  localparam logic [1:0] CMD_DECRYPT = 2'd3;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_INCOMPLETE = 2'd1;
  localparam logic [1:0] ST_SAME       = 2'd2;

  // saturate to Z, fold J into I
  function automatic letter_t canon_cipher(input letter_t v);
    letter_t t;
    t = (v > LETTER_Z) ? LETTER_Z : v;
    if (t == LETTER_J) begin
      t = LETTER_I;
    end
    return t;
  endfunction

  function automatic letter_t cell_of(input coord_t r, input coord_t k);
    return {r[2:0], 2'b00} + {2'b00, r} + {2'b00, k};
  endfunction

  function automatic coord_t row_of(input letter_t c);
    coord_t r;
    r = 3'd0;
    if (c >= letter_t'(SIDE))     r = 3'd1;
    if (c >= letter_t'(2 * SIDE)) r = 3'd2;
    if (c >= letter_t'(3 * SIDE)) r = 3'd3;
    if (c >= letter_t'(4 * SIDE)) r = 3'd4;
    return r;
  endfunction

  function automatic coord_t col_of(input letter_t c);
    letter_t t;
    t = c - cell_of(row_of(c), 3'd0);
    return t[2:0];
  endfunction

  function automatic coord_t prev_of(input coord_t k);
    return (k == 3'd0) ? coord_t'(SIDE - 1) : k - 3'd1;
  endfunction

endpackage

`default_nettype wire

>>> hdl/pfd_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module pfd_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 25,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> hdl/playfair_digram_decryptor.sv
// Playfair key square builder and digram decryptor.
// Input channel (in_valid/in_ready) carries one command word: clear, add key
// letter, finish square or decrypt digram. Only decrypt returns a word on the
// output channel (out_valid/out_ready): two plain letters and a status.
// Clear and add key letter are done when accepted. Finish walks over the
// 26-letter alphabet, one letter per cycle through the single letter-store
// unit. Decrypt makes two reads of the position memory and then two reads
// of the square memory, each with one read port and registered read data,
// in the steps POS2, CELL, SQ2 and SQ3. A decrypt on an incomplete square or
// with identical letters goes straight to the result step SQ3.
// in_ready is high only between commands; one command is worked at a time.
// The result sits in an output register; when the receiver stalls, the next
// decrypt holds in its last step until the register frees, and no other
// command is taken while it holds.
// Reset empties the square (present flags and fill count); the memories keep
// stale contents that are never used before they are rewritten.
`timescale 1ns / 1ps
`default_nettype none

module playfair_digram_decryptor (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_command,
  input  wire logic [4:0] in_letter_first,
  input  wire logic [4:0] in_letter_second,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [4:0]      out_plain_first,
  output logic [4:0]      out_plain_second,
  output logic [1:0]      out_status
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FILL = 3'd1;
  localparam logic [2:0] S_POS2 = 3'd2;
  localparam logic [2:0] S_CELL = 3'd3;
  localparam logic [2:0] S_SQ2  = 3'd4;
  localparam logic [2:0] S_SQ3  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [4:0] fill_r;
  logic [pfd_pkg::ALPHA-1:0] present_r;
  pfd_pkg::letter_t k_r, y_r, c1_r, d2_r, p1_r;
  logic [1:0] stat_r;
  logic out_valid_r;
  pfd_pkg::letter_t out_first_r, out_second_r;
  logic [1:0] out_status_r;

  logic in_fire;
  logic out_free;
  pfd_pkg::letter_t src, sv, pidx;
  logic src_ok, store_en;
  pfd_pkg::letter_t x, y;
  logic [1:0] dec_stat;
  pfd_pkg::letter_t pos_rd_addr, pos_rd_data, sq_rd_addr, sq_rd_data;
  pfd_pkg::coord_t r1, k1, r2, k2;
  pfd_pkg::letter_t d1, d2;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // shared letter-store unit
  always_comb begin
    src = (state_r == S_FILL) ? k_r : in_letter_first;
    sv = (src == pfd_pkg::LETTER_J) ? pfd_pkg::LETTER_I : src;
    src_ok = (src < pfd_pkg::letter_t'(pfd_pkg::ALPHA));
    pidx = src_ok ? sv : 5'd0;
    store_en = ((in_fire && (in_command == pfd_pkg::CMD_ADD)) || (state_r == S_FILL))
               && src_ok && !present_r[pidx]
               && (fill_r < 5'(pfd_pkg::CELLS));
  end

  always_comb begin
    x = pfd_pkg::canon_cipher(in_letter_first);
    y = pfd_pkg::canon_cipher(in_letter_second);
    if (fill_r < 5'(pfd_pkg::CELLS)) begin
      dec_stat = pfd_pkg::ST_INCOMPLETE;
    end else if (x == y) begin
      dec_stat = pfd_pkg::ST_SAME;
    end else begin
      dec_stat = pfd_pkg::ST_OK;
    end
  end

  always_comb begin
    r1 = pfd_pkg::row_of(c1_r);
    k1 = pfd_pkg::col_of(c1_r);
    r2 = pfd_pkg::row_of(pos_rd_data);
    k2 = pfd_pkg::col_of(pos_rd_data);
    if (r1 == r2) begin
      d1 = pfd_pkg::cell_of(r1, pfd_pkg::prev_of(k1));
      d2 = pfd_pkg::cell_of(r2, pfd_pkg::prev_of(k2));
    end else if (k1 == k2) begin
      d1 = pfd_pkg::cell_of(pfd_pkg::prev_of(r1), k1);
      d2 = pfd_pkg::cell_of(pfd_pkg::prev_of(r2), k2);
    end else begin
      d1 = pfd_pkg::cell_of(r1, k2);
      d2 = pfd_pkg::cell_of(r2, k1);
    end
  end

  assign pos_rd_addr = (state_r == S_IDLE) ? x : y_r;
  assign sq_rd_addr = (state_r == S_CELL) ? d1 : d2_r;

  pfd_ram #(.WIDTH(pfd_pkg::LW), .DEPTH(pfd_pkg::ALPHA)) u_pos_ram (
    .clk     (clk),
    .wr_en   (store_en),
    .wr_addr (sv),
    .wr_data (fill_r),
    .rd_addr (pos_rd_addr),
    .rd_data (pos_rd_data)
  );

  pfd_ram #(.WIDTH(pfd_pkg::LW), .DEPTH(pfd_pkg::CELLS)) u_sq_ram (
    .clk     (clk),
    .wr_en   (store_en),
    .wr_addr (fill_r),
    .wr_data (sv),
    .rd_addr (sq_rd_addr),
    .rd_data (sq_rd_data)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_command)
            pfd_pkg::CMD_FINISH: state_nxt = S_FILL;
            pfd_pkg::CMD_DECRYPT: state_nxt = (dec_stat == pfd_pkg::ST_OK) ? S_POS2 : S_SQ3;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_FILL: begin
        if (k_r == pfd_pkg::letter_t'(pfd_pkg::ALPHA - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_POS2: state_nxt = S_CELL;
      S_CELL: state_nxt = S_SQ2;
      S_SQ2: state_nxt = S_SQ3;
      S_SQ3: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r <= 5'd0;
      present_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_fire && (in_command == pfd_pkg::CMD_CLEAR)) begin
        fill_r <= 5'd0;
        present_r <= '0;
      end else if (store_en) begin
        fill_r <= fill_r + 5'd1;
        present_r[pidx] <= 1'b1;
      end
      if ((state_r == S_SQ3) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      k_r <= 5'd0;
      y_r <= y;
      stat_r <= dec_stat;
    end else if (state_r == S_FILL) begin
      k_r <= k_r + 5'd1;
    end
    if (state_r == S_POS2) begin
      c1_r <= pos_rd_data;
    end
    if (state_r == S_CELL) begin
      d2_r <= d2;
    end
    if (state_r == S_SQ2) begin
      p1_r <= sq_rd_data;
    end
    if ((state_r == S_SQ3) && out_free) begin
      out_status_r <= stat_r;
      out_first_r <= (stat_r == pfd_pkg::ST_OK) ? p1_r : 5'd0;
      out_second_r <= (stat_r == pfd_pkg::ST_OK) ? sq_rd_data : 5'd0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_plain_first = out_first_r;
  assign out_plain_second = out_second_r;
  assign out_status = out_status_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= 5'(pfd_pkg::CELLS))
    else $error("fill count beyond square size");

  a_fill_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(present_r) == int'(fill_r))
    else $error("present flags disagree with fill count");

  a_dec_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_command == pfd_pkg::CMD_DECRYPT)) |=> !in_ready)
    else $error("ready during decrypt");

  a_result_state: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_SQ3))
    else $error("result raised outside result step");

endmodule

`default_nettype wire
